// ===== design/safs_pkg.sv =====
`timescale 1ns / 1ps

package safs_pkg;

    // Field widths
    localparam int REQ_W      = 1;
    localparam int ELAPSED_W  = 16;
    localparam int ANIM_W     = 4;
    localparam int SLOT_POS_W = 4;
    localparam int FRAME_W    = 8;
    localparam int LIST_POS_W = 4;
    localparam int EDGE_W     = 17;
    localparam int COLS_W     = 5;
    localparam int ROWS_W     = 5;
    localparam int DUR_W      = 16;
    localparam int ACC_W      = 32;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DURATION   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ANIMATION = 2'd3;

    // Register values after reset
    localparam logic [COLS_W-1:0] RST_GRID_COLUMNS     = 5'd1;
    localparam logic [ROWS_W-1:0] RST_GRID_ROWS        = 5'd1;
    localparam logic [DUR_W-1:0]  RST_FRAME_DURATION   = 16'd1000;
    localparam logic [ANIM_W-1:0] RST_ACTIVE_ANIMATION = 4'd0;

    // Request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // Default sizes
    localparam int DEF_MAX_ANIMATIONS  = 16;
    localparam int DEF_MAX_LIST_LENGTH = 16;
    localparam int DEF_MAX_GRID_SIDE   = 16;

    // Shared divider geometry
    localparam int DIV_REM_W = 32;
    localparam int DIV_DSR_W = 16;
    localparam int DIV_QUO_W = 17;
    localparam int DIV_BIT_W = $clog2(DIV_QUO_W);

    // Q1.16 scaling
    localparam int Q_SHIFT = 16;

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [ELAPSED_W-1:0]  elapsed;
        logic [ANIM_W-1:0]     anim_slot;
        logic [SLOT_POS_W-1:0] slot_position;
        logic [FRAME_W-1:0]    sheet_frame;
        logic                  slot_last;
    } t_in_item;

    typedef struct packed {
        logic                  is_load_ack;
        logic [LIST_POS_W-1:0] list_position;
        logic [FRAME_W-1:0]    frame_number;
        logic [EDGE_W-1:0]     u_start;
        logic [EDGE_W-1:0]     u_end;
        logic [EDGE_W-1:0]     v_start;
        logic [EDGE_W-1:0]     v_end;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic do_load;
        logic tick_mul;
        logic wrap_start;
        logic mem_read;
        logic frame_start;
        logic edge_lo;
        logic edge_hi;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_is_load;
        logic div_busy;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/safs_ram.sv =====
`timescale 1ns / 1ps

module safs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/safs_div.sv =====
`timescale 1ns / 1ps

module safs_div #(
    parameter int REM_W = safs_pkg::DIV_REM_W,
    parameter int DSR_W = safs_pkg::DIV_DSR_W,
    parameter int QUO_W = safs_pkg::DIV_QUO_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [REM_W-1:0]           i_dividend,
    input  logic [DSR_W-1:0]           i_divisor,
    input  logic [$clog2(QUO_W)-1:0]   i_top_bit,
    output logic                       o_busy,
    output logic [QUO_W-1:0]           o_quotient,
    output logic [REM_W-1:0]           o_remainder
);

    localparam int BW = $clog2(QUO_W);
    localparam int TW = DSR_W + QUO_W;
    localparam int CW = (REM_W > TW) ? REM_W : TW;

    logic             r_busy;
    logic [BW-1:0]    r_bit;
    logic [REM_W-1:0] r_rem;
    logic [TW-1:0]    r_trial;
    logic [QUO_W-1:0] r_quo;
    logic             w_fits;

    // Shifted divisor fits under the partial remainder
    assign w_fits = (CW'(r_rem) >= CW'(r_trial));

    // Busy flag: one quotient bit per cycle, top bit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_bit == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // Restoring division step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_dividend;
            r_trial <= TW'(i_divisor) << i_top_bit;
            r_quo   <= '0;
            r_bit   <= i_top_bit;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= r_rem - REM_W'(r_trial);
            end
            r_quo   <= {r_quo[QUO_W-2:0], w_fits};
            r_trial <= r_trial >> 1;
            r_bit   <= r_bit - BW'(1);
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== design/safs_ctrl.sv =====
`timescale 1ns / 1ps

module safs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  safs_pkg::t_dp_status  i_status,
    output safs_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_WRAP,
        ST_TDIV_W,
        ST_READ,
        ST_FRAME,
        ST_CR_W,
        ST_EDGE_LO,
        ST_LO_W,
        ST_EDGE_HI,
        ST_HI_W,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence one transaction at a time
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.in_is_load ? ST_LOAD : ST_MUL;
                end
            end
            ST_LOAD:    n_state = ST_FINISH;
            ST_MUL:     n_state = ST_WRAP;
            ST_WRAP:    n_state = ST_TDIV_W;
            ST_TDIV_W: begin
                if (!i_status.div_busy) n_state = ST_READ;
            end
            ST_READ:    n_state = ST_FRAME;
            ST_FRAME:   n_state = ST_CR_W;
            ST_CR_W: begin
                if (!i_status.div_busy) n_state = ST_EDGE_LO;
            end
            ST_EDGE_LO: n_state = ST_LO_W;
            ST_LO_W: begin
                if (!i_status.div_busy) n_state = ST_EDGE_HI;
            end
            ST_EDGE_HI: n_state = ST_HI_W;
            ST_HI_W: begin
                if (!i_status.div_busy) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Decode commands from the current state
    always_comb begin
        o_cmd             = '0;
        o_cmd.clr_step    = (r_state == ST_CLEAR);
        o_cmd.capture     = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.do_load     = (r_state == ST_LOAD);
        o_cmd.tick_mul    = (r_state == ST_MUL);
        o_cmd.wrap_start  = (r_state == ST_WRAP);
        o_cmd.mem_read    = (r_state == ST_READ);
        o_cmd.frame_start = (r_state == ST_FRAME);
        o_cmd.edge_lo     = (r_state == ST_EDGE_LO);
        o_cmd.edge_hi     = (r_state == ST_EDGE_HI);
        o_cmd.finish      = (r_state == ST_FINISH) && i_status.out_free;
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/safs_dp.sv =====
`timescale 1ns / 1ps

module safs_dp #(
    parameter int MAX_ANIMATIONS  = safs_pkg::DEF_MAX_ANIMATIONS,
    parameter int MAX_LIST_LENGTH = safs_pkg::DEF_MAX_LIST_LENGTH,
    parameter int MAX_GRID_SIDE   = safs_pkg::DEF_MAX_GRID_SIDE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  safs_pkg::t_in_item                  i_in_data,
    output safs_pkg::t_out_item                 o_out_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_cfg_wr_en,
    input  logic [safs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [safs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  safs_pkg::t_dp_cmd                   i_cmd,
    output safs_pkg::t_dp_status                o_status
);

    localparam int ANW   = (MAX_ANIMATIONS > 1) ? $clog2(MAX_ANIMATIONS) : 1;
    localparam int PW    = (MAX_LIST_LENGTH > 1) ? $clog2(MAX_LIST_LENGTH) : 1;
    localparam int LW    = $clog2(MAX_LIST_LENGTH + 1);
    localparam int GW    = $clog2(MAX_GRID_SIDE + 1);
    localparam int DEPTH = MAX_ANIMATIONS * MAX_LIST_LENGTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SPW   = safs_pkg::DUR_W + LW;
    localparam int CLW   = 2 * GW;
    localparam int NCODE = 1 << safs_pkg::ANIM_W;
    localparam int BW    = safs_pkg::DIV_BIT_W;
    localparam int RW    = safs_pkg::DIV_REM_W;
    localparam int DW    = safs_pkg::DIV_DSR_W;
    localparam int QW    = safs_pkg::DIV_QUO_W;

    localparam logic [BW-1:0] TIME_TOP  = BW'(PW - 1);
    localparam logic [BW-1:0] FRAME_TOP = BW'(safs_pkg::FRAME_W - 1);
    localparam logic [BW-1:0] EDGE_TOP  = BW'(safs_pkg::DIV_QUO_W - 1);

    // Configuration registers
    logic [safs_pkg::COLS_W-1:0] r_grid_columns;
    logic [safs_pkg::ROWS_W-1:0] r_grid_rows;
    logic [safs_pkg::DUR_W-1:0]  r_frame_duration;
    logic [safs_pkg::ANIM_W-1:0] r_active_animation;

    // Block state
    logic [safs_pkg::ACC_W-1:0] r_acc;
    logic [LW-1:0]              r_len [MAX_ANIMATIONS];
    logic [AW-1:0]              r_clr_addr;

    // Per-transaction registers
    safs_pkg::t_in_item          r_item;
    logic [LW-1:0]               r_len_cur;
    logic [SPW-1:0]              r_span;
    logic [CLW-1:0]              r_cells;
    logic [PW-1:0]               r_pos;
    logic [safs_pkg::FRAME_W-1:0] r_frm;
    logic [GW-1:0]               r_col;
    logic [GW-1:0]               r_row;
    logic [safs_pkg::EDGE_W-1:0] r_u_start;
    logic [safs_pkg::EDGE_W-1:0] r_v_start;
    logic                        r_out_valid;
    safs_pkg::t_out_item         r_out_data;
    safs_pkg::t_out_item         n_out_data;

    // Combinational
    logic [ANW-1:0]              w_anim_tbl [NCODE];
    logic [ANW-1:0]              w_anim;
    logic [safs_pkg::DUR_W-1:0]  w_dur;
    logic [GW-1:0]               w_cols;
    logic [GW-1:0]               w_rows;
    logic [safs_pkg::ACC_W-1:0]  w_acc_eff;
    logic [PW-1:0]               w_pos;
    logic [safs_pkg::FRAME_W-1:0] w_frm;
    logic [safs_pkg::FRAME_W-1:0] w_sheet;
    logic                        w_load_ok;
    logic [AW-1:0]               w_load_addr;
    logic [AW-1:0]               w_rd_addr;
    logic                        w_ram_we;
    logic [AW-1:0]               w_ram_waddr;
    logic [safs_pkg::FRAME_W-1:0] w_ram_wdata;
    logic [safs_pkg::FRAME_W-1:0] w_ram_rdata;

    // Divider ports
    logic          w_a_start, w_b_start;
    logic [RW-1:0] w_a_dvd, w_b_dvd;
    logic [DW-1:0] w_a_dsr, w_b_dsr;
    logic [BW-1:0] w_a_top, w_b_top;
    logic          w_a_busy, w_b_busy;
    logic [QW-1:0] w_a_quo, w_b_quo;
    logic [RW-1:0] w_a_rem, w_b_rem;

    // Wrap table for the active list code
    for (genvar g = 0; g < NCODE; g++) begin : g_anim_wrap
        assign w_anim_tbl[g] = ANW'(g % MAX_ANIMATIONS);
    end
    assign w_anim = w_anim_tbl[r_active_animation];

    // Sanitize grid size and duration
    always_comb begin
        if (r_grid_columns == '0) begin
            w_cols = GW'(1);
        end else if (32'(r_grid_columns) > 32'(MAX_GRID_SIDE)) begin
            w_cols = GW'(MAX_GRID_SIDE);
        end else begin
            w_cols = GW'(r_grid_columns);
        end
        if (r_grid_rows == '0) begin
            w_rows = GW'(1);
        end else if (32'(r_grid_rows) > 32'(MAX_GRID_SIDE)) begin
            w_rows = GW'(MAX_GRID_SIDE);
        end else begin
            w_rows = GW'(r_grid_rows);
        end
    end
    assign w_dur = (r_frame_duration == '0) ? safs_pkg::DUR_W'(1) : r_frame_duration;

    // Restart the cycle once the list has played out
    assign w_acc_eff = (r_acc >= safs_pkg::ACC_W'(r_span)) ? '0 : r_acc;

    // Position, frame and sheet frame selection
    assign w_pos   = (r_len_cur == '0) ? '0 : PW'(w_a_quo);
    assign w_frm   = (r_len_cur == '0) ? '0 : w_ram_rdata;
    assign w_sheet = (16'(w_frm) >= 16'(r_cells)) ? '0 : w_frm;

    // Load addressing
    assign w_load_ok = (32'(r_item.anim_slot) < 32'(MAX_ANIMATIONS)) &&
                       (32'(r_item.slot_position) < 32'(MAX_LIST_LENGTH));
    assign w_load_addr = AW'(int'(r_item.anim_slot) * MAX_LIST_LENGTH)
                       + AW'(r_item.slot_position);
    assign w_rd_addr   = AW'(int'(w_anim) * MAX_LIST_LENGTH) + AW'(w_pos);

    // Memory write: clearing sweep or load
    assign w_ram_we    = i_cmd.clr_step || (i_cmd.do_load && w_load_ok);
    assign w_ram_waddr = i_cmd.clr_step ? r_clr_addr : w_load_addr;
    assign w_ram_wdata = i_cmd.clr_step ? '0 : r_item.sheet_frame;

    safs_ram #(
        .WIDTH (safs_pkg::FRAME_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (i_cmd.mem_read),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_rdata)
    );

    // Divider A: time over duration, then column edges
    assign w_a_start = i_cmd.wrap_start || i_cmd.edge_lo || i_cmd.edge_hi;
    always_comb begin
        w_a_dvd = w_acc_eff;
        w_a_dsr = w_dur;
        w_a_top = TIME_TOP;
        if (i_cmd.edge_lo) begin
            w_a_dvd = RW'(GW'(w_b_rem)) << safs_pkg::Q_SHIFT;
            w_a_dsr = DW'(w_cols);
            w_a_top = EDGE_TOP;
        end else if (i_cmd.edge_hi) begin
            w_a_dvd = (RW'(r_col) + RW'(1)) << safs_pkg::Q_SHIFT;
            w_a_dsr = DW'(w_cols);
            w_a_top = EDGE_TOP;
        end
    end

    // Divider B: sheet frame over columns, then row edges
    assign w_b_start = i_cmd.frame_start || i_cmd.edge_lo || i_cmd.edge_hi;
    always_comb begin
        w_b_dvd = RW'(w_sheet);
        w_b_dsr = DW'(w_cols);
        w_b_top = FRAME_TOP;
        if (i_cmd.edge_lo) begin
            w_b_dvd = RW'(GW'(w_b_quo)) << safs_pkg::Q_SHIFT;
            w_b_dsr = DW'(w_rows);
            w_b_top = EDGE_TOP;
        end else if (i_cmd.edge_hi) begin
            w_b_dvd = (RW'(r_row) + RW'(1)) << safs_pkg::Q_SHIFT;
            w_b_dsr = DW'(w_rows);
            w_b_top = EDGE_TOP;
        end
    end

    safs_div #(
        .REM_W (RW),
        .DSR_W (DW),
        .QUO_W (QW)
    ) u_div_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_a_start),
        .i_dividend  (w_a_dvd),
        .i_divisor   (w_a_dsr),
        .i_top_bit   (w_a_top),
        .o_busy      (w_a_busy),
        .o_quotient  (w_a_quo),
        .o_remainder (w_a_rem)
    );

    safs_div #(
        .REM_W (RW),
        .DSR_W (DW),
        .QUO_W (QW)
    ) u_div_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_b_start),
        .i_dividend  (w_b_dvd),
        .i_divisor   (w_b_dsr),
        .i_top_bit   (w_b_top),
        .o_busy      (w_b_busy),
        .o_quotient  (w_b_quo),
        .o_remainder (w_b_rem)
    );

    // Control state: registers, lengths, time, clear sweep, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns     <= safs_pkg::RST_GRID_COLUMNS;
            r_grid_rows        <= safs_pkg::RST_GRID_ROWS;
            r_frame_duration   <= safs_pkg::RST_FRAME_DURATION;
            r_active_animation <= safs_pkg::RST_ACTIVE_ANIMATION;
            r_acc              <= '0;
            r_clr_addr         <= '0;
            r_out_valid        <= 1'b0;
            for (int i = 0; i < MAX_ANIMATIONS; i++) begin
                r_len[i] <= (i == 0) ? LW'(1) : '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    safs_pkg::CFG_GRID_COLUMNS:
                        r_grid_columns <= safs_pkg::COLS_W'(i_cfg_wdata);
                    safs_pkg::CFG_GRID_ROWS:
                        r_grid_rows <= safs_pkg::ROWS_W'(i_cfg_wdata);
                    safs_pkg::CFG_FRAME_DURATION:
                        r_frame_duration <= safs_pkg::DUR_W'(i_cfg_wdata);
                    safs_pkg::CFG_ACTIVE_ANIMATION:
                        r_active_animation <= safs_pkg::ANIM_W'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.do_load && w_load_ok && r_item.slot_last) begin
                r_len[ANW'(r_item.anim_slot)] <= LW'(r_item.slot_position) + LW'(1);
            end
            if (i_cmd.wrap_start) begin
                r_acc <= w_acc_eff;
            end else if (i_cmd.finish && (r_item.req_type == safs_pkg::REQ_TICK)) begin
                r_acc <= r_acc + safs_pkg::ACC_W'(r_item.elapsed);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Assemble the result of the transaction in hand
    always_comb begin
        n_out_data = '0;
        if (r_item.req_type == safs_pkg::REQ_LOAD) begin
            n_out_data.is_load_ack = 1'b1;
        end else begin
            n_out_data.list_position = safs_pkg::LIST_POS_W'(r_pos);
            n_out_data.frame_number  = r_frm;
            n_out_data.u_start       = r_u_start;
            n_out_data.u_end         = w_a_quo;
            n_out_data.v_start       = r_v_start;
            n_out_data.v_end         = w_b_quo;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.tick_mul) begin
            r_len_cur <= r_len[w_anim];
            r_span    <= SPW'(w_dur) * SPW'(r_len[w_anim]);
            r_cells   <= CLW'(w_cols) * CLW'(w_rows);
        end
        if (i_cmd.mem_read) begin
            r_pos <= w_pos;
        end
        if (i_cmd.frame_start) begin
            r_frm <= w_frm;
        end
        if (i_cmd.edge_lo) begin
            r_col <= GW'(w_b_rem);
            r_row <= GW'(w_b_quo);
        end
        if (i_cmd.edge_hi) begin
            r_u_start <= w_a_quo;
            r_v_start <= w_b_quo;
        end
        if (i_cmd.finish) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_status.clr_last   = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.in_is_load = (i_in_data.req_type == safs_pkg::REQ_LOAD);
    assign o_status.div_busy   = w_a_busy || w_b_busy;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule

// ===== design/sprite_animation_frame_sequencer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Signals                               Transaction when
// input     in         i_in_valid, o_in_ready, i_in_data     i_in_valid && o_in_ready
// output    out        o_out_valid, i_out_ready, o_out_data  o_out_valid && i_out_ready
// config    in         i_cfg_wr_en, i_cfg_index, i_cfg_wdata i_cfg_wr_en
//
// One transaction is worked at a time. A load writes its list entry (when in range) in ST_LOAD
// and its acknowledge is registered in ST_FINISH. A tick is worked by two shared restoring
// dividers, one quotient bit per cycle: time/duration, frame/columns, then 17-bit Q1.16
// edges for start and end in turn.
// After reset all MAX_ANIMATIONS * MAX_LIST_LENGTH entries of the frame list memory
// are cleared, one entry per cycle; inputs are held off meanwhile.
// A stalled output holds its result while the next transaction is accepted and worked.

module sprite_animation_frame_sequencer_unit #(
    parameter int MAX_ANIMATIONS  = safs_pkg::DEF_MAX_ANIMATIONS,
    parameter int MAX_LIST_LENGTH = safs_pkg::DEF_MAX_LIST_LENGTH,
    parameter int MAX_GRID_SIDE   = safs_pkg::DEF_MAX_GRID_SIDE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  safs_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output safs_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_wr_en,
    input  logic [safs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [safs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    safs_pkg::t_dp_cmd    w_cmd;
    safs_pkg::t_dp_status w_status;

    // Sequencer
    safs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Storage, dividers and result register
    safs_dp #(
        .MAX_ANIMATIONS  (MAX_ANIMATIONS),
        .MAX_LIST_LENGTH (MAX_LIST_LENGTH),
        .MAX_GRID_SIDE   (MAX_GRID_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
